>>> rtl/rls_pkg.sv
// Shared types and constants for the RGB levels stretch block.
// Used by rls_prep, rls_div_cell and rgb_levels_stretch_core.
package rls_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned NumSteps = ChanW;  // one quotient bit per cell
  localparam int unsigned IdxW     = 3;

  localparam logic [ChanW-1:0] FullScale = 8'd255;

  // register indexes on the config port
  localparam logic [IdxW-1:0] RegBlackRed   = 3'd0;
  localparam logic [IdxW-1:0] RegBlackGreen = 3'd1;
  localparam logic [IdxW-1:0] RegBlackBlue  = 3'd2;
  localparam logic [IdxW-1:0] RegWhiteRed   = 3'd3;
  localparam logic [IdxW-1:0] RegWhiteGreen = 3'd4;
  localparam logic [IdxW-1:0] RegWhiteBlue  = 3'd5;
  localparam logic [IdxW-1:0] RegInvert     = 3'd6;

  typedef enum logic [1:0] {
    ModeZero,
    ModeFull,
    ModeDiv
  } mode_e;

  // one color channel on its way down the divider chain
  typedef struct packed {
    mode_e            mode;
    logic [ChanW-1:0] dvs;     // white - black
    logic [ChanW-1:0] rem;     // partial remainder, below dvs in ModeDiv
    logic [ChanW-1:0] num_lo;  // dividend bits still to shift in
    logic [ChanW-1:0] quo;     // quotient bits so far
  } lane_t;

  typedef lane_t [NumLanes-1:0] lane_vec_t;

  typedef struct packed {
    logic [NumLanes-1:0][ChanW-1:0] black;
    logic [NumLanes-1:0][ChanW-1:0] white;
    logic                           invert;
  } levels_t;

endpackage

>>> rtl/rls_prep.sv
// Front cell: optional inversion, level compare and dividend setup per channel.
// Depends on rls_pkg.
module rls_prep (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rls_pkg::levels_t                             levels_i,
  input  logic                                         valid_i,
  output logic                                         ready_o,
  input  logic [rls_pkg::NumLanes-1:0][rls_pkg::ChanW-1:0] pix_i,
  output logic                                         valid_o,
  input  logic                                         ready_i,
  output rls_pkg::lane_vec_t                           data_o
);
  import rls_pkg::*;

  logic      valid_q;
  lane_vec_t data_d, data_q;

  always_comb begin
    logic [ChanW-1:0]   v;
    logic [ChanW-1:0]   d;
    logic [2*ChanW-1:0] num;
    for (int i = 0; i < NumLanes; i++) begin
      v   = levels_i.invert ? (FullScale - pix_i[i]) : pix_i[i];
      d   = v - levels_i.black[i];
      // d * 255 as (d << 8) - d
      num = {d, {ChanW{1'b0}}} - {{ChanW{1'b0}}, d};
      data_d[i].dvs    = levels_i.white[i] - levels_i.black[i];
      data_d[i].rem    = num[2*ChanW-1:ChanW];
      data_d[i].num_lo = num[ChanW-1:0];
      data_d[i].quo    = '0;
      if (v <= levels_i.black[i]) begin
        data_d[i].mode = ModeZero;
      end else if (v >= levels_i.white[i]) begin
        data_d[i].mode = ModeFull;  // also covers white at or below black
      end else begin
        data_d[i].mode = ModeDiv;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/rls_div_cell.sv
// One restoring-division step for all three channels, with its own beat register.
// Depends on rls_pkg.
module rls_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rls_pkg::lane_vec_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rls_pkg::lane_vec_t data_o
);
  import rls_pkg::*;

  logic      valid_q;
  lane_vec_t data_d, data_q;

  always_comb begin
    logic [ChanW:0] trial;
    logic           qbit;
    for (int i = 0; i < NumLanes; i++) begin
      trial = {data_i[i].rem, data_i[i].num_lo[ChanW-1]};
      qbit  = (trial >= {1'b0, data_i[i].dvs});
      data_d[i]        = data_i[i];
      data_d[i].num_lo = {data_i[i].num_lo[ChanW-2:0], 1'b0};
      data_d[i].quo    = {data_i[i].quo[ChanW-2:0], qbit};
      if (qbit) begin
        data_d[i].rem = ChanW'(trial - {1'b0, data_i[i].dvs});
      end else begin
        data_d[i].rem = trial[ChanW-1:0];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/rgb_levels_stretch_core.sv
// Per-channel levels / contrast stretch of an RGB pixel stream.
// Instantiates rls_prep and a chain of rls_div_cell; depends on rls_pkg.
//
// Usage:
//   Input channel: in_valid_i with pixel_red_i/green_i/blue_i; a beat is taken
//   when in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o with out_red_o/green_o/blue_o; a beat leaves
//   when out_valid_o is high and out_stall_i is low.
//   Config channel: cfg_valid_i, cfg_index_i, cfg_data_i, always ready.
//   Index 0..2 black red/green/blue, 3..5 white red/green/blue, 6 invert.
//   Write config only while no pixel is in flight.
// Pipeline:
//   One setup cell plus eight division cells, the division cells each
//   producing one quotient bit of (v - black) * 255 / (white - black).
//   Throughput is one pixel per clock while out_stall_i is low.
// Stall: every cell holds its beat while the next one is full and stalled;
//   empty cells keep filling, so in_stall_o rises only once the whole
//   chain is full and out_stall_i is high.
// Reset: all cells empty, black levels 0, white levels 255, invert off.
module rgb_levels_stretch_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [rls_pkg::ChanW-1:0] pixel_red_i,
  input  logic [rls_pkg::ChanW-1:0] pixel_green_i,
  input  logic [rls_pkg::ChanW-1:0] pixel_blue_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rls_pkg::ChanW-1:0] out_red_o,
  output logic [rls_pkg::ChanW-1:0] out_green_o,
  output logic [rls_pkg::ChanW-1:0] out_blue_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rls_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [rls_pkg::ChanW-1:0] cfg_data_i
);
  import rls_pkg::*;

  levels_t levels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q.black  <= '0;
      levels_q.white  <= {NumLanes{FullScale}};
      levels_q.invert <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBlackRed:   levels_q.black[0] <= cfg_data_i;
        RegBlackGreen: levels_q.black[1] <= cfg_data_i;
        RegBlackBlue:  levels_q.black[2] <= cfg_data_i;
        RegWhiteRed:   levels_q.white[0] <= cfg_data_i;
        RegWhiteGreen: levels_q.white[1] <= cfg_data_i;
        RegWhiteBlue:  levels_q.white[2] <= cfg_data_i;
        RegInvert:     levels_q.invert   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [NumLanes-1:0][ChanW-1:0] pix;
  assign pix[0] = pixel_red_i;
  assign pix[1] = pixel_green_i;
  assign pix[2] = pixel_blue_i;

  // stage k output feeds cell k; stg_ready[k] is that consumer's ready
  lane_vec_t           stg_data  [NumSteps+1];
  logic [NumSteps:0]   stg_valid;
  logic [NumSteps:0]   stg_ready;
  logic                in_ready;

  rls_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .levels_i (levels_q),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready),
    .pix_i    (pix),
    .valid_o  (stg_valid[0]),
    .ready_i  (stg_ready[0]),
    .data_o   (stg_data[0])
  );

  for (genvar k = 0; k < NumSteps; k++) begin : g_cell
    rls_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  assign stg_ready[NumSteps] = !out_stall_i;
  assign in_stall_o          = !in_ready;
  assign out_valid_o         = stg_valid[NumSteps];

  logic [NumLanes-1:0][ChanW-1:0] res;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      case (stg_data[NumSteps][i].mode)
        ModeZero: res[i] = '0;
        ModeFull: res[i] = FullScale;
        ModeDiv:  res[i] = stg_data[NumSteps][i].quo;
        default:  res[i] = '0;
      endcase
    end
  end

  assign out_red_o   = res[0];
  assign out_green_o = res[1];
  assign out_blue_o  = res[2];

  // input side stalls only when the chain is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&stg_valid) && out_stall_i)
    else $error("input stalled with room in the chain");

  // a strictly interior red value never reaches full scale
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stg_data[NumSteps][0].mode == ModeDiv)
    |-> stg_data[NumSteps][0].quo != FullScale)
    else $error("red quotient out of range");

  // green partial remainder is below the divisor at the end of the chain
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid[NumSteps] && (stg_data[NumSteps][1].mode == ModeDiv)
    |-> stg_data[NumSteps][1].rem < stg_data[NumSteps][1].dvs)
    else $error("green remainder not below divisor");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for rgb_levels_stretch_core: levels stretch checked against a local predictor.
// Depends on rls_pkg and the core RTL. Holds the pixel scoreboard class and the top module.

class levels_scoreboard;
  typedef struct packed {
    logic [rls_pkg::ChanW-1:0] red;
    logic [rls_pkg::ChanW-1:0] green;
    logic [rls_pkg::ChanW-1:0] blue;
  } rgb_t;

  logic [rls_pkg::ChanW-1:0] black_lvl [3];
  logic [rls_pkg::ChanW-1:0] white_lvl [3];
  bit                        invert;
  rgb_t                      expected_pixels [$];
  int unsigned               errors;
  int unsigned               checked;

  function new();
    black_lvl = '{8'd0, 8'd0, 8'd0};
    white_lvl = '{8'd255, 8'd255, 8'd255};
    invert    = 1'b0;
    errors    = 0;
    checked   = 0;
  endfunction

  function void set_level(logic [rls_pkg::IdxW-1:0] idx, logic [rls_pkg::ChanW-1:0] data);
    case (idx)
      rls_pkg::RegBlackRed:   black_lvl[0] = data;
      rls_pkg::RegBlackGreen: black_lvl[1] = data;
      rls_pkg::RegBlackBlue:  black_lvl[2] = data;
      rls_pkg::RegWhiteRed:   white_lvl[0] = data;
      rls_pkg::RegWhiteGreen: white_lvl[1] = data;
      rls_pkg::RegWhiteBlue:  white_lvl[2] = data;
      rls_pkg::RegInvert:     invert = data[0];
      default: ;  // out-of-range index is dropped
    endcase
  endfunction

  // white at or below black falls out as a hard threshold from the first two tests
  function logic [rls_pkg::ChanW-1:0] map_level(logic [7:0] v, logic [7:0] blk,
                                                 logic [7:0] wht);
    logic [15:0] num;
    logic [15:0] den;
    logic [15:0] quo;
    if (v <= blk) return '0;
    if (v >= wht) return rls_pkg::FullScale;
    num = {8'd0, v} - {8'd0, blk};
    den = {8'd0, wht} - {8'd0, blk};
    quo = (num * 16'd255) / den;
    return quo[7:0];
  endfunction

  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0] ch [3];
    rgb_t       want;
    ch = '{r, g, b};
    if (invert) begin
      foreach (ch[i]) ch[i] = rls_pkg::FullScale - ch[i];
    end
    want.red   = map_level(ch[0], black_lvl[0], white_lvl[0]);
    want.green = map_level(ch[1], black_lvl[1], white_lvl[1]);
    want.blue  = map_level(ch[2], black_lvl[2], white_lvl[2]);
    expected_pixels.push_back(want);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) begin  // keep the log short on a broken build
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  task check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t want;
    if (expected_pixels.size() == 0) begin
      report($sformatf("unexpected output beat r=%0d g=%0d b=%0d", r, g, b));
      return;
    end
    want = expected_pixels.pop_front();
    if (want.red !== r || want.green !== g || want.blue !== b) begin
      report($sformatf("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       checked, want.red, want.green, want.blue, r, g, b));
    end
    checked++;
  endtask

  function int unsigned pending();
    return expected_pixels.size();
  endfunction
endclass

module tb_top;
  import rls_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ChanW-1:0] pix_red = '0;
  logic [ChanW-1:0] pix_green = '0;
  logic [ChanW-1:0] pix_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ChanW-1:0] res_red;
  logic [ChanW-1:0] res_green;
  logic [ChanW-1:0] res_blue;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [ChanW-1:0] cfg_data = '0;

  levels_scoreboard sb = new();

  bit          send_idle = 1'b1;
  bit          stall_on = 1'b1;
  bit          stalled = 1'b0;
  int unsigned hold_cnt = 0;

  rgb_levels_stretch_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_red_i   (pix_red),
    .pixel_green_i (pix_green),
    .pixel_blue_i  (pix_blue),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_red_o     (res_red),
    .out_green_o   (res_green),
    .out_blue_o    (res_blue),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("rgb_levels_stretch_core verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side backpressure
  always @(negedge clk) begin
    if (hold_cnt == 0) begin
      stalled  = stall_on && ($urandom_range(0, 3) == 0);
      hold_cnt = stalled ? pick_gap() : $urandom_range(1, 6);
    end
    hold_cnt--;
    out_stall <= stalled;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel(res_red, res_green, res_blue);
    end
  end

  task write_reg(logic [IdxW-1:0] idx, logic [ChanW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_level(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    pix_red   <= r;
    pix_green <= g;
    pix_blue  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(r, g, b);
  endtask

  // stop sending, wait out every pending pixel, then let the chain settle
  task drain(int unsigned tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task write_levels(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                    logic [7:0] wr, logic [7:0] wg, logic [7:0] wb, logic [7:0] inv);
    write_reg(RegBlackRed, br);
    write_reg(RegBlackGreen, bg);
    write_reg(RegBlackBlue, bb);
    write_reg(RegWhiteRed, wr);
    write_reg(RegWhiteGreen, wg);
    write_reg(RegWhiteBlue, wb);
    write_reg(RegInvert, inv);
  endtask

  function automatic logic [7:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // channel value aimed at one of the channel's levels, or anywhere
  function automatic logic [7:0] pick_channel(int c);
    int val;
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    val = $urandom_range(0, 1) ? sb.black_lvl[c] : sb.white_lvl[c];
    val = val + int'($urandom_range(0, 4)) - 2;
    if (val < 0) val = 0;
    if (val > 255) val = 255;
    return sb.invert ? 8'(255 - val) : 8'(val);
  endfunction

  initial begin
    logic [7:0] blk [3];
    logic [7:0] wht [3];
    logic [7:0] inv_data;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset levels pass pixels through
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'h55, 8'hAA, 8'h01);
    send_pixel(8'h80, 8'h7F, 8'hFE);
    drain(12);

    // mid-range stretch, blue as threshold; invert data has stray high bits
    write_levels(8'd64, 8'd0, 8'd200, 8'd192, 8'd255, 8'd10, 8'hFE);
    write_reg(3'd7, 8'hFF);  // index past the last register: ignored
    send_pixel(8'd64, 8'd0, 8'd200);
    send_pixel(8'd65, 8'd1, 8'd201);
    send_pixel(8'd191, 8'd254, 8'd9);
    send_pixel(8'd192, 8'd255, 8'd10);
    send_pixel(8'd128, 8'd128, 8'd11);
    drain(12);

    // equal levels at both ends on red and green, inverted
    write_levels(8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 8'd255, 8'h01);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd254, 8'd1);
    send_pixel(8'd254, 8'd1, 8'd0);
    drain(12);

    // span of one on red and blue: nothing strictly between the levels
    write_levels(8'd0, 8'd1, 8'd100, 8'd1, 8'd255, 8'd101, 8'h00);
    send_pixel(8'd0, 8'd1, 8'd100);
    send_pixel(8'd1, 8'd2, 8'd101);
    send_pixel(8'd2, 8'd0, 8'd99);
    drain(12);

    for (int phase = 0; phase < 10; phase++) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 4))
          0: begin
            blk[c] = pick_extreme();
            wht[c] = pick_extreme();
          end
          1: begin
            blk[c] = 8'($urandom_range(0, 255));
            wht[c] = 8'($urandom_range(0, 255));
          end
          default: begin
            blk[c] = 8'($urandom_range(0, 254));
            wht[c] = 8'($urandom_range(blk[c] + 1, 255));
          end
        endcase
      end
      inv_data = 8'($urandom_range(0, 255));
      write_levels(blk[0], blk[1], blk[2], wht[0], wht[1], wht[2], inv_data);
      if ($urandom_range(0, 2) == 0) write_reg(3'd7, 8'($urandom_range(0, 255)));

      send_idle = (phase % 4 == 0) || (phase % 4 == 2);
      stall_on  = (phase % 4 == 0) || (phase % 4 == 3);

      for (int n = 0; n < 150; n++) begin
        if (phase == 5 && n == 75) drain(0);
        send_pixel(pick_channel(0), pick_channel(1), pick_channel(2));
      end
      drain(12);
    end

    if (sb.errors == 0) begin
      $display("rgb_levels_stretch_core verification clean");
    end else begin
      $display("rgb_levels_stretch_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rls_pkg.sv
rtl/rls_prep.sv
rtl/rls_div_cell.sv
rtl/rgb_levels_stretch_core.sv
tb/tb_top.sv
